FILE: src/cpcs_pkg.sv
package cpcs_pkg;

	// Command codes carried in the action field
	localparam logic [2:0] ACT_ADD      = 3'd0;
	localparam logic [2:0] ACT_REMOVE   = 3'd1;
	localparam logic [2:0] ACT_CONTAINS = 3'd2;
	localparam logic [2:0] ACT_GET_NTH  = 3'd3;
	localparam logic [2:0] ACT_CLEAR    = 3'd4;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	// Field widths of one result transaction
	localparam int unsigned EX_W   = 4;
	localparam int unsigned EY_W   = 3;
	localparam int unsigned USED_W = 6;

	// Result transaction, lowest field in the lowest bits
	typedef struct packed {
		logic [USED_W-1:0] used_count;
		logic [EY_W-1:0]   entry_y;
		logic [EX_W-1:0]   entry_x;
		logic              found;
		logic [1:0]        status;
	} result_t;

	// Table update requested by the sequencer
	typedef struct packed {
		logic fill;   // mark slot valid and store the pair
		logic drop;   // mark slot free
		logic wipe;   // free every slot
	} tbl_op_t;

endpackage

FILE: src/cpcs_slot_table.sv
module cpcs_slot_table #(
	parameter int unsigned SLOTS = 32,
	parameter int unsigned XW    = 4,
	parameter int unsigned YW    = 3,
	parameter int unsigned IW    = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cpcs_pkg::tbl_op_t op,
	input  logic [IW-1:0]     wr_idx,
	input  logic [XW-1:0]     wr_x,
	input  logic [YW-1:0]     wr_y,
	input  logic              rd_en,
	input  logic [IW-1:0]     rd_idx,
	output logic              rd_valid,
	output logic [XW-1:0]     rd_x,
	output logic [YW-1:0]     rd_y
);

	logic [SLOTS-1:0] slot_valid_q;
	logic [XW-1:0]    mem_x [SLOTS];
	logic [YW-1:0]    mem_y [SLOTS];
	logic             rd_valid_q;
	logic [XW-1:0]    rd_x_q;
	logic [YW-1:0]    rd_y_q;

	// Update the valid marks; wipe frees every slot at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (op.wipe) begin
			slot_valid_q <= '0;
		end else if (op.fill) begin
			slot_valid_q[wr_idx] <= 1'b1;
		end else if (op.drop) begin
			slot_valid_q[wr_idx] <= 1'b0;
		end
	end

	// Store the pair of a newly filled slot
	always_ff @(posedge clk) begin
		if (op.fill) begin
			mem_x[wr_idx] <= wr_x;
			mem_y[wr_idx] <= wr_y;
		end
	end

	// Registered read port for the scan
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_valid_q <= slot_valid_q[rd_idx];
			rd_x_q     <= mem_x[rd_idx];
			rd_y_q     <= mem_y[rd_idx];
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_x     = rd_x_q;
	assign rd_y     = rd_y_q;

endmodule

FILE: src/crosspoint_connection_set_core.sv
// Crosspoint connection set: a table of SLOTS slots, each holding one x,y
// crosspoint pair, with a count of the slots in use.
// Commands enter on the s_ group (action, coord_x, coord_y, entry_index);
// every command returns exactly one result transaction on the m_ group
// (status, found, entry_x, entry_y, used_count).
// Get-nth, and in-range add, remove and contains, scan every slot once
// through a single registered read port and one compare unit, then go to
// the finish state, where the result is registered. Clear, out-of-range
// add, remove and contains, and unused action codes skip the scan and go
// straight from idle to the finish state. s_tready is high only while no
// command is in progress, so a new command is not accepted until the last
// one has left the finish state. The result sits in an output register;
// the next command is accepted while it still waits, and a command that
// finishes while the receiver stalls holds its result until the register
// is free.
// Reset empties the table (all valid marks cleared at once), zeroes the
// count and drops any pending result.
module crosspoint_connection_set_core #(
	parameter int unsigned SLOTS   = 32,
	parameter int unsigned X_LINES = 16,
	parameter int unsigned Y_LINES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // action[2:0], coord_x[10:3], coord_y[18:11],
	                               // entry_index[26:19], zero[31:27]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // status[1:0], found[2], entry_x[6:3],
	                               // entry_y[9:7], used_count[15:10]
);

	localparam int unsigned XW = (X_LINES > 1) ? $clog2(X_LINES) : 1;
	localparam int unsigned YW = (Y_LINES > 1) ? $clog2(Y_LINES) : 1;
	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]    state_q;
	logic [2:0]    act_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [7:0]    want_q;
	logic          range_q;
	logic [CW-1:0] scan_q;
	logic          rd_live_s1;
	logic [IW-1:0] idx_s1;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;
	logic [CW-1:0] seen_q;
	logic          nth_q;
	logic [cpcs_pkg::EX_W-1:0] nth_x_q;
	logic [cpcs_pkg::EY_W-1:0] nth_y_q;
	logic [CW-1:0] count_q;
	logic          out_valid_q;
	cpcs_pkg::result_t out_q;

	logic [2:0]    in_act;
	logic [7:0]    in_x;
	logic [7:0]    in_y;
	logic          in_range;
	logic          in_take;
	logic          rd_en;
	logic          rd_valid;
	logic [XW-1:0] rd_x;
	logic [YW-1:0] rd_y;
	logic          match;
	logic          scan_done;
	logic          fin_go;
	cpcs_pkg::tbl_op_t op_d;
	cpcs_pkg::tbl_op_t op;
	logic [IW-1:0] wr_idx;
	logic [CW-1:0] count_d;
	cpcs_pkg::result_t res_d;

	// Unpack the command transaction
	assign in_act   = s_tdata[2:0];
	assign in_x     = s_tdata[10:3];
	assign in_y     = s_tdata[18:11];
	assign in_range = (int'(in_x) < X_LINES) && (int'(in_y) < Y_LINES);
	assign s_tready = (state_q == S_IDLE);
	assign in_take  = s_tvalid && s_tready;

	// Drive the read port while slots remain
	assign rd_en     = (state_q == S_SCAN) && (scan_q != CW'(SLOTS));
	assign scan_done = (state_q == S_SCAN) && (scan_q == CW'(SLOTS)) && !rd_live_s1;
	assign fin_go    = (state_q == S_FINISH) && (!out_valid_q || m_tready);

	// Shared compare unit: one slot per cycle
	assign match = rd_valid && (rd_x == x_q) && (rd_y == y_q);

	cpcs_slot_table #(
		.SLOTS (SLOTS),
		.XW    (XW),
		.YW    (YW),
		.IW    (IW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.wr_idx   (wr_idx),
		.wr_x     (x_q),
		.wr_y     (y_q),
		.rd_en    (rd_en),
		.rd_idx   (scan_q[IW-1:0]),
		.rd_valid (rd_valid),
		.rd_x     (rd_x),
		.rd_y     (rd_y)
	);

	// Sequencer: accept, scan, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rd_live_s1 <= 1'b0;
		end else begin
			rd_live_s1 <= rd_en;
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if ((in_range && (in_act inside {cpcs_pkg::ACT_ADD,
								cpcs_pkg::ACT_REMOVE, cpcs_pkg::ACT_CONTAINS}))
								|| (in_act == cpcs_pkg::ACT_GET_NTH)) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the command
	always_ff @(posedge clk) begin
		if (in_take) begin
			act_q   <= in_act;
			x_q     <= in_x[XW-1:0];
			y_q     <= in_y[YW-1:0];
			want_q  <= s_tdata[26:19];
			range_q <= in_range;
		end
	end

	// Advance the scan and collect the first match, first free slot and nth entry
	always_ff @(posedge clk) begin
		if (in_take) begin
			scan_q <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			nth_q  <= 1'b0;
			seen_q <= '0;
		end else begin
			if (rd_en) begin
				scan_q <= scan_q + 1'b1;
			end
			idx_s1 <= scan_q[IW-1:0];
			if (rd_live_s1) begin
				if (match && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= idx_s1;
				end
				if (!rd_valid && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_s1;
				end
				if (rd_valid) begin
					if ((8'(seen_q) == want_q) && !nth_q) begin
						nth_q   <= 1'b1;
						nth_x_q <= cpcs_pkg::EX_W'(rd_x);
						nth_y_q <= cpcs_pkg::EY_W'(rd_y);
					end
					seen_q <= seen_q + 1'b1;
				end
			end
		end
	end

	// Work out the result and the table update
	always_comb begin
		res_d         = '0;
		res_d.status  = cpcs_pkg::ST_OK;
		op_d          = '0;
		wr_idx        = free_idx_q;
		count_d       = count_q;
		case (act_q)
			cpcs_pkg::ACT_ADD: begin
				if (!range_q) begin
					res_d.status = cpcs_pkg::ST_RANGE;
				end else if (hit_q) begin
					res_d.status = cpcs_pkg::ST_OK;
				end else if (!free_q) begin
					res_d.status = cpcs_pkg::ST_FULL;
				end else begin
					op_d.fill = 1'b1;
					count_d   = count_q + 1'b1;
				end
			end
			cpcs_pkg::ACT_REMOVE: begin
				wr_idx = hit_idx_q;
				if (!range_q) begin
					res_d.status = cpcs_pkg::ST_RANGE;
				end else if (!hit_q) begin
					res_d.status = cpcs_pkg::ST_MISSING;
				end else begin
					op_d.drop = 1'b1;
					if (count_q != '0) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			cpcs_pkg::ACT_CONTAINS: begin
				if (!range_q) begin
					res_d.status = cpcs_pkg::ST_RANGE;
				end else begin
					res_d.found = hit_q;
				end
			end
			cpcs_pkg::ACT_GET_NTH: begin
				if (nth_q) begin
					res_d.entry_x = nth_x_q;
					res_d.entry_y = nth_y_q;
				end else begin
					res_d.status = cpcs_pkg::ST_MISSING;
				end
			end
			cpcs_pkg::ACT_CLEAR: begin
				op_d.wipe = 1'b1;
				count_d   = '0;
			end
			default: begin
			end
		endcase
		res_d.used_count = cpcs_pkg::USED_W'(count_d);
	end

	// Apply the update only in the cycle the result is registered
	assign op = fin_go ? op_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fin_go) begin
			count_q <= count_d;
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

FILE: src/cpcs_checker.sv
module cpcs_checker #(
	parameter int unsigned SLOTS = 32
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One command at a time: ready drops after an accepted command
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command accepted while busy");

	// The count never exceeds the table size
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (SLOTS > 63) || (int'(m_tdata[15:10]) <= SLOTS))
		else $error("used count beyond table size");

	// Found only with status ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == cpcs_pkg::ST_OK)
		else $error("found set on failed command");

	// Entry fields zero on a failed command
	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != cpcs_pkg::ST_OK) |-> m_tdata[9:3] == 7'd0)
		else $error("entry fields set on failed command");

endmodule

bind crosspoint_connection_set_core cpcs_checker #(.SLOTS(SLOTS)) u_cpcs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
